FILE: hw/rtl/rtch_pkg.sv
// Shared constants and types for the ray/triangle closest-hit core.
package rtch_pkg;

   localparam int COORD_WIDTH_DEF    = 16;
   localparam int DIST_FRAC_BITS_DEF = 16;
   localparam int DIST_WIDTH         = 32;
   localparam int NUM_CFG_REGS       = 6;
   localparam int CFG_IDX_WIDTH      = 3;

   typedef enum logic [CFG_IDX_WIDTH-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5
   } cfg_reg_type;

   localparam logic [15:0] DIR_Z_RESET = 16'sd4096;

   // status handed from the front end to the back end with each queued entry
   typedef struct packed {
      logic cand;
      logic last;
   } tri_flags_type;

endpackage

FILE: hw/rtl/rtch_front.sv
// Front end: edge vectors, cross and dot products, sign tests, one request per cycle while the output is not stalled.
module rtch_front #(
   parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF,
   parameter int PW          = 4 * COORD_WIDTH + 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] vtx [9],
   input  logic                          in_last,
   input  logic signed [COORD_WIDTH-1:0] org [3],
   input  logic signed [COORD_WIDTH-1:0] dir [3],
   output logic                          out_valid,
   input  logic                          out_ready,
   output rtch_pkg::tri_flags_type       out_flags,
   output logic        [PW-1:0]          out_num,
   output logic        [PW-1:0]          out_den
);
   localparam int DW = COORD_WIDTH + 1;
   localparam int MW = 2 * DW + 2;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff;
   logic signed [DW-1:0] e1_ff [3], e2_ff [3], s_ff [3], d_ff [3];
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_last_ff;
   logic signed [MW-1:0] h_ff [3], q_ff [3];
   logic signed [DW-1:0] e1b_ff [3], e2b_ff [3], sb_ff [3], db_ff [3];
   logic                 s3_valid_ff, s3_valid_in;
   logic                 s3_last_ff;
   logic signed [PW-1:0] a_ff, u_ff, v_ff, t_ff;
   logic                 s4_valid_ff, s4_valid_in;
   rtch_pkg::tri_flags_type s4_flags_ff;
   logic        [PW-1:0] s4_num_ff, s4_den_ff;

   logic adv;
   assign adv      = !s4_valid_ff || out_ready;
   assign in_ready = adv;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;
   assign s4_valid_in = s3_valid_ff;

   logic signed [MW-1:0] h_c [3], q_c [3];
   logic signed [PW-1:0] a_c, u_c, v_c, t_c;
   logic signed [PW-1:0] an, un, vn, tn;
   logic                 cand_c;

   always_comb begin
      h_c[0] = MW'(d_ff[1] * e2_ff[2]) - MW'(d_ff[2] * e2_ff[1]);
      h_c[1] = MW'(d_ff[2] * e2_ff[0]) - MW'(d_ff[0] * e2_ff[2]);
      h_c[2] = MW'(d_ff[0] * e2_ff[1]) - MW'(d_ff[1] * e2_ff[0]);
      q_c[0] = MW'(s_ff[1] * e1_ff[2]) - MW'(s_ff[2] * e1_ff[1]);
      q_c[1] = MW'(s_ff[2] * e1_ff[0]) - MW'(s_ff[0] * e1_ff[2]);
      q_c[2] = MW'(s_ff[0] * e1_ff[1]) - MW'(s_ff[1] * e1_ff[0]);
      a_c = PW'(e1b_ff[0] * h_ff[0]) + PW'(e1b_ff[1] * h_ff[1]) + PW'(e1b_ff[2] * h_ff[2]);
      u_c = PW'(sb_ff[0] * h_ff[0]) + PW'(sb_ff[1] * h_ff[1]) + PW'(sb_ff[2] * h_ff[2]);
      v_c = PW'(db_ff[0] * q_ff[0]) + PW'(db_ff[1] * q_ff[1]) + PW'(db_ff[2] * q_ff[2]);
      t_c = PW'(e2b_ff[0] * q_ff[0]) + PW'(e2b_ff[1] * q_ff[1]) + PW'(e2b_ff[2] * q_ff[2]);
      if (a_ff[PW-1]) begin
         an = -a_ff; un = -u_ff; vn = -v_ff; tn = -t_ff;
      end else begin
         an = a_ff; un = u_ff; vn = v_ff; tn = t_ff;
      end
      cand_c = (a_ff != '0) && !un[PW-1] && !vn[PW-1] && ((un + vn) <= an)
               && !tn[PW-1] && (tn != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i]  <= DW'(vtx[3+i]) - DW'(vtx[i]);
            e2_ff[i]  <= DW'(vtx[6+i]) - DW'(vtx[i]);
            s_ff[i]   <= DW'(org[i]) - DW'(vtx[i]);
            d_ff[i]   <= DW'(dir[i]);
            h_ff[i]   <= h_c[i];
            q_ff[i]   <= q_c[i];
            e1b_ff[i] <= e1_ff[i];
            e2b_ff[i] <= e2_ff[i];
            sb_ff[i]  <= s_ff[i];
            db_ff[i]  <= d_ff[i];
         end
         s1_last_ff <= in_last;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
         a_ff <= a_c; u_ff <= u_c; v_ff <= v_c; t_ff <= t_c;
         s4_flags_ff.cand <= cand_c;
         s4_flags_ff.last <= s3_last_ff;
         s4_num_ff <= tn;
         s4_den_ff <= an;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_flags = s4_flags_ff;
   assign out_num   = s4_num_ff;
   assign out_den   = s4_den_ff;
endmodule

FILE: hw/rtl/rtch_queue.sv
// Short FIFO that decouples the front end from the divide/reduce back end.
module rtch_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   localparam int AW = $clog2(DEPTH);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [AW:0]      cnt_ff;
   logic             wr, rd;

   assign wr_ready = cnt_ff != (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

FILE: hw/rtl/rtch_back.sv
// Back end: restoring divider for the distance and the running closest-hit minimum.
module rtch_back #(
   parameter int PW             = 72,
   parameter int DIST_FRAC_BITS = rtch_pkg::DIST_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  rtch_pkg::tri_flags_type             in_flags,
   input  logic [PW-1:0]                       in_num,
   input  logic [PW-1:0]                       in_den,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [rtch_pkg::DIST_WIDTH-1:0]     rsp_nearest_distance
);
   localparam int DWID = rtch_pkg::DIST_WIDTH;
   localparam int NB   = PW + DIST_FRAC_BITS;
   localparam int CW   = $clog2(NB + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_type;

   state_type        state_ff;
   logic [NB-1:0]    num_ff;
   logic [PW:0]      rem_ff;
   logic [PW-1:0]    den_ff;
   logic [DWID:0]    quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             last_ff;
   logic [DWID-1:0]  best_ff;
   logic             any_ff;
   logic             out_v_ff;
   logic             out_v_in;
   logic             out_load;
   logic             out_hit_ff;
   logic [DWID-1:0]  out_dist_ff;

   logic [PW:0]      rem_sh;
   logic             ge;
   logic [DWID-1:0]  dist_c;
   logic [DWID-1:0]  best_upd;

   assign rem_sh   = {rem_ff[PW-1:0], num_ff[NB-1]};
   assign ge       = rem_sh >= {1'b0, den_ff};
   assign dist_c   = quo_ff[DWID] ? '1 : quo_ff[DWID-1:0];
   assign best_upd = (dist_c < best_ff) ? dist_c : best_ff;
   assign in_ready = (state_ff == ST_IDLE) && (!out_v_ff || rsp_ready);

   assign out_load = ((state_ff == ST_IDLE) && in_valid && in_ready && !in_flags.cand
                      && in_flags.last)
                     || ((state_ff == ST_DONE) && (!out_v_ff || rsp_ready) && last_ff);
   assign out_v_in = out_load || (out_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         best_ff  <= '1;
         any_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         case (state_ff)
            ST_IDLE: begin
               if (in_valid && in_ready) begin
                  num_ff  <= {in_num, DIST_FRAC_BITS'(0)};
                  den_ff  <= in_den;
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  cnt_ff  <= CW'(NB);
                  last_ff <= in_flags.last;
                  if (in_flags.cand) begin
                     state_ff <= ST_DIV;
                  end else if (in_flags.last) begin
                     out_hit_ff  <= any_ff;
                     out_dist_ff <= best_ff;
                     best_ff     <= '1;
                     any_ff      <= 1'b0;
                  end
               end
            end
            ST_DIV: begin
               rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
               num_ff <= {num_ff[NB-2:0], 1'b0};
               quo_ff <= quo_ff[DWID] ? quo_ff : {quo_ff[DWID-1:0], ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!out_v_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
                  if (last_ff) begin
                     out_hit_ff  <= 1'b1;
                     out_dist_ff <= best_upd;
                     best_ff     <= '1;
                     any_ff      <= 1'b0;
                  end else begin
                     best_ff <= best_upd;
                     any_ff  <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_hit              = out_hit_ff;
   assign rsp_nearest_distance = out_dist_ff;
endmodule

FILE: hw/rtl/ray_triangle_closest_hit_core.sv
// Top level of the ray/triangle closest-hit core: CSRs, front end, queue, back end.
// A four-stage front end takes one triangle request per cycle when not stalled and
// does the exact Moller-Trumbore sign tests; a four-entry queue feeds the back end.
// Triangles that miss leave the back end from the idle state; a candidate hit runs a
// one-bit-per-cycle restoring divider, and the back end takes no new triangle until
// it is done. A response is emitted only for a request marked last_triangle. The user
// must write the ray CSRs only while the core is idle; the core does not enforce it.
module ray_triangle_closest_hit_core #(
   parameter int COORD_WIDTH    = rtch_pkg::COORD_WIDTH_DEF,
   parameter int DIST_FRAC_BITS = rtch_pkg::DIST_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtch_pkg::CFG_IDX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_v0_x,
   input  logic signed [COORD_WIDTH-1:0] req_v0_y,
   input  logic signed [COORD_WIDTH-1:0] req_v0_z,
   input  logic signed [COORD_WIDTH-1:0] req_v1_x,
   input  logic signed [COORD_WIDTH-1:0] req_v1_y,
   input  logic signed [COORD_WIDTH-1:0] req_v1_z,
   input  logic signed [COORD_WIDTH-1:0] req_v2_x,
   input  logic signed [COORD_WIDTH-1:0] req_v2_y,
   input  logic signed [COORD_WIDTH-1:0] req_v2_z,
   input  logic                          req_last_triangle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [rtch_pkg::DIST_WIDTH-1:0] rsp_nearest_distance
);
   localparam int PW = 4 * COORD_WIDTH + 8;
   localparam int QW = 2 * PW + 2;

   logic signed [COORD_WIDTH-1:0] cfg_ff [rtch_pkg::NUM_CFG_REGS];
   logic signed [COORD_WIDTH-1:0] org [3], dir [3], vtx [9];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rtch_pkg::NUM_CFG_REGS; i++) cfg_ff[i] <= '0;
         cfg_ff[rtch_pkg::REG_DIR_Z] <= COORD_WIDTH'(signed'(rtch_pkg::DIR_Z_RESET));
      end else if (csr_valid) begin
         case (csr_index)
            rtch_pkg::REG_ORIGIN_X: cfg_ff[rtch_pkg::REG_ORIGIN_X] <= csr_data;
            rtch_pkg::REG_ORIGIN_Y: cfg_ff[rtch_pkg::REG_ORIGIN_Y] <= csr_data;
            rtch_pkg::REG_ORIGIN_Z: cfg_ff[rtch_pkg::REG_ORIGIN_Z] <= csr_data;
            rtch_pkg::REG_DIR_X:    cfg_ff[rtch_pkg::REG_DIR_X]    <= csr_data;
            rtch_pkg::REG_DIR_Y:    cfg_ff[rtch_pkg::REG_DIR_Y]    <= csr_data;
            rtch_pkg::REG_DIR_Z:    cfg_ff[rtch_pkg::REG_DIR_Z]    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org[i] = cfg_ff[i];
         dir[i] = cfg_ff[3+i];
      end
      vtx[0] = req_v0_x; vtx[1] = req_v0_y; vtx[2] = req_v0_z;
      vtx[3] = req_v1_x; vtx[4] = req_v1_y; vtx[5] = req_v1_z;
      vtx[6] = req_v2_x; vtx[7] = req_v2_y; vtx[8] = req_v2_z;
   end

   logic                    f_valid, f_ready, b_valid, b_ready;
   rtch_pkg::tri_flags_type f_flags, b_flags;
   logic [PW-1:0]           f_num, f_den, b_num, b_den;
   logic [QW-1:0]           q_out;

   rtch_front #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .vtx,
      .in_last(req_last_triangle), .org, .dir, .out_valid(f_valid),
      .out_ready(f_ready), .out_flags(f_flags), .out_num(f_num), .out_den(f_den)
   );

   rtch_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready),
      .wr_data({f_flags, f_num, f_den}), .rd_valid(b_valid), .rd_ready(b_ready),
      .rd_data(q_out)
   );

   assign b_flags = q_out[QW-1:QW-2];
   assign b_num   = q_out[2*PW-1:PW];
   assign b_den   = q_out[PW-1:0];

   rtch_back #(.PW(PW), .DIST_FRAC_BITS(DIST_FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(b_valid), .in_ready(b_ready), .in_flags(b_flags),
      .in_num(b_num), .in_den(b_den), .rsp_valid, .rsp_ready, .rsp_hit,
      .rsp_nearest_distance
   );

`ifndef SYNTH
   // a miss always reports the all-ones distance
   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_nearest_distance == '1)
      else $error("miss without all-ones distance");
   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_distance))
      else $error("response changed while stalled");
`endif
endmodule

FILE: tb/tb.sv
// Testbench for the ray/triangle closest-hit core: directed and random meshes checked against a predictor.
`timescale 1ns / 1ps
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rtch_pkg::CFG_IDX_WIDTH-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_v0_x = '0, req_v0_y = '0, req_v0_z = '0;
   logic signed [15:0] req_v1_x = '0, req_v1_y = '0, req_v1_z = '0;
   logic signed [15:0] req_v2_x = '0, req_v2_y = '0, req_v2_z = '0;
   logic req_last_triangle = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [31:0] rsp_nearest_distance;

   ray_triangle_closest_hit_core dut (.*);

   typedef struct {
      logic hit;
      logic [31:0] distance;
   } mesh_result_type;

   mesh_result_type hits_due[$];
   logic signed [15:0] ray_reg [rtch_pkg::NUM_CFG_REGS];
   logic [31:0] best_dist;
   logic seen_hit;
   int errors = 0;
   int n_tri = 0;
   int n_meshes = 0;
   int n_hits = 0;
   int hold_cycles = 0;
   bit stall_on = 1'b1;

   initial forever #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

   // exact Moller-Trumbore on 64-bit products
   function automatic void predict_triangle(input logic signed [15:0] vtx [9], input logic lst);
      logic signed [63:0] p0 [3], e1 [3], e2 [3], s [3], d [3], h [3], q [3];
      logic signed [63:0] a, uu, vv, tt;
      logic [127:0] quo;
      logic [31:0] distance;
      mesh_result_type r;
      for (int i = 0; i < 3; i++) begin
         p0[i] = vtx[i];
         e1[i] = 64'(vtx[3+i]) - p0[i];
         e2[i] = 64'(vtx[6+i]) - p0[i];
         s[i] = 64'(ray_reg[i]) - p0[i];
         d[i] = ray_reg[3+i];
      end
      h[0] = d[1]*e2[2] - d[2]*e2[1];
      h[1] = d[2]*e2[0] - d[0]*e2[2];
      h[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
      uu = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
      vv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (a != 0) begin
         if (a < 0) begin
            a = -a; uu = -uu; vv = -vv; tt = -tt;
         end
         if (uu >= 0 && vv >= 0 && uu + vv <= a && tt > 0) begin
            quo = ({64'd0, tt} << 16) / {64'd0, a};
            distance = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
            seen_hit = 1'b1;
            if (distance < best_dist) best_dist = distance;
         end
      end
      if (lst) begin
         r.hit = seen_hit;
         r.distance = best_dist;
         hits_due.push_back(r);
         if (seen_hit) n_hits++;
         n_meshes++;
         best_dist = '1;
         seen_hit = 1'b0;
      end
   endfunction

   // valid stays up after a request is taken; drain() or an idle gap in the next send drops it
   task automatic send_triangle(input logic signed [15:0] vtx [9], input logic lst);
      int idle;
      idle = $urandom_range(0, 3);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_v0_x <= vtx[0]; req_v0_y <= vtx[1]; req_v0_z <= vtx[2];
      req_v1_x <= vtx[3]; req_v1_y <= vtx[4]; req_v1_z <= vtx[5];
      req_v2_x <= vtx[6]; req_v2_y <= vtx[7]; req_v2_z <= vtx[8];
      req_last_triangle <= lst;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_triangle(vtx, lst);
      n_tri++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (hits_due.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_ray(input rtch_pkg::cfg_reg_type idx, input logic signed [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      ray_reg[idx] = val;
      @(negedge clock);
   endtask

   task automatic set_ray(input logic signed [15:0] o [3], input logic signed [15:0] d [3]);
      drain();
      write_ray(rtch_pkg::REG_ORIGIN_X, o[0]); write_ray(rtch_pkg::REG_ORIGIN_Y, o[1]);
      write_ray(rtch_pkg::REG_ORIGIN_Z, o[2]); write_ray(rtch_pkg::REG_DIR_X, d[0]);
      write_ray(rtch_pkg::REG_DIR_Y, d[1]); write_ray(rtch_pkg::REG_DIR_Z, d[2]);
      csr_valid <= 1'b0;
   endtask

   // triangle around the point the ray reaches at a random depth
   function automatic void make_triangle(output logic signed [15:0] vtx [9], input int span);
      int c [3];
      int k;
      k = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++)
         c[i] = ray_reg[i] + ((int'(ray_reg[3+i]) * k) >>> 1);
      for (int j = 0; j < 9; j++)
         vtx[j] = 16'(c[j%3] + $signed($urandom_range(0, 2*span)) - span);
   endfunction

   function automatic void noise_triangle(output logic signed [15:0] vtx [9]);
      for (int j = 0; j < 9; j++) vtx[j] = 16'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hits_due.size() == 0) begin
            $display("%0t unexpected response hit=%0b dist=%h", $realtime, rsp_hit,
                     rsp_nearest_distance);
            errors++;
         end else begin
            if (rsp_hit !== hits_due[0].hit) begin
               $display("%0t hit mismatch expected %0b actual %0b", $realtime,
                        hits_due[0].hit, rsp_hit);
               errors++;
            end
            if (rsp_nearest_distance !== hits_due[0].distance) begin
               $display("%0t distance mismatch expected %h actual %h", $realtime,
                        hits_due[0].distance, rsp_nearest_distance);
               errors++;
            end
            void'(hits_due.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (stall_on) rsp_ready <= ($urandom_range(0, 3) == 0);
      else rsp_ready <= 1'b1;
   end

   task automatic test_directed();
      logic signed [15:0] vtx [9];
      logic signed [15:0] o [3], d [3];
      // flat triangle at z=1 facing the default ray
      vtx = '{-16'sd4096, -16'sd4096, 16'sd4096, 16'sd4096, -16'sd4096, 16'sd4096,
              16'sd0, 16'sd4096, 16'sd4096};
      send_triangle(vtx, 1'b1);
      vtx = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      send_triangle(vtx, 1'b1);                       // degenerate
      vtx = '{-16'sd4096, -16'sd4096, -16'sd4096, 16'sd4096, -16'sd4096, -16'sd4096,
              16'sd0, 16'sd4096, -16'sd4096};
      send_triangle(vtx, 1'b1);                       // behind origin
      vtx = '{-16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd4096,
              16'sd0, 16'sd0, 16'sd4096};
      send_triangle(vtx, 1'b1);                       // parallel
      vtx = '{-16'sd32768, -16'sd32768, 16'sd1, 16'sd32767, -16'sd32768, 16'sd1,
              16'sd0, 16'sd32767, 16'sd1};
      send_triangle(vtx, 1'b0);                       // t just above zero
      vtx = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
              16'sd0, 16'sd32767, 16'sd32767};
      send_triangle(vtx, 1'b1);
      o = '{16'sd0, 16'sd0, 16'sd0};
      d = '{16'sd0, 16'sd0, 16'sd1};
      set_ray(o, d);                                  // tiny direction: large distance
      vtx = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
              16'sd0, 16'sd32767, 16'sd32767};
      send_triangle(vtx, 1'b1);
      o = '{16'sd32767, -16'sd32768, 16'sd32767};
      d = '{-16'sd32768, 16'sd32767, -16'sd32768};
      set_ray(o, d);
      vtx = '{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768,
              16'sd32767, -16'sd32768, 16'sd0};
      send_triangle(vtx, 1'b1);
   endtask

   task automatic test_random(input int count);
      logic signed [15:0] vtx [9];
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 7) make_triangle(vtx, 1 << $urandom_range(6, 14));
         else noise_triangle(vtx);
         send_triangle(vtx, (n == count - 1) || ($urandom_range(0, 5) == 0));
      end
   endtask

   task automatic test_ray_settings();
      logic signed [15:0] o [3], d [3];
      for (int r = 0; r < 8; r++) begin
         for (int i = 0; i < 3; i++) begin
            o[i] = 16'($urandom);
            d[i] = (r % 3 == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 16384)) - 8192);
         end
         set_ray(o, d);
         test_random(100);
      end
   endtask

   task automatic test_backpressure();
      logic signed [15:0] vtx [9];
      hold_cycles = 400;
      for (int n = 0; n < 60; n++) begin
         make_triangle(vtx, 4096);
         send_triangle(vtx, n % 3 == 2);
      end
      drain();
      stall_on = 1'b0;
      test_random(100);
      stall_on = 1'b1;
      vtx = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      send_triangle(vtx, 1'b1);
   endtask

   initial begin
      best_dist = '1;
      seen_hit = 1'b0;
      for (int i = 0; i < rtch_pkg::NUM_CFG_REGS; i++) ray_reg[i] = '0;
      ray_reg[rtch_pkg::REG_DIR_Z] = rtch_pkg::DIR_Z_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_ray_settings();
      test_backpressure();
      drain();
      $display("covered %0d triangles in %0d meshes, %0d meshes with a hit", n_tri,
               n_meshes, n_hits);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
